@@ rtl/s2da_pkg.sv @@
package s2da_pkg;

   localparam int unsigned VALUE_W    = 64;
   localparam int unsigned NUM_DIGITS = 20;
   localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
   localparam int unsigned STEPS      = 8;
   localparam int unsigned NUM_STAGES = VALUE_W / STEPS;
   localparam int unsigned IDX_W      = 5;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_NINE  = 8'd57;

   // One word on its way through the conversion pipeline.
   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] bin;
      logic [BCD_W-1:0]   bcd;
   } word_type;

endpackage

@@ rtl/signed_binary_to_decimal_ascii_unit.sv @@
// Path: a word enters the sign register at the edge that accepts it, then passes the eight
//   conversion stages, is loaded into the emitter, and each character leaves through the output
//   register; a stall on the result side ripples back through them.
// Throughput: one character per cycle while the result side does not stall; a word of N
//   characters (1 to 20) holds the emitter until its last character is sent, and only then is the next word loaded.
// Reset: synchronous, active high; clears every valid bit and the emitter's busy flag, no clearing pass.
module signed_binary_to_decimal_ascii_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last_char
);

   // Handshake chain: stage 0 is the sign stage, stages 1..NUM_STAGES the conversion
   // stages; the emitter sits on the end. Each stage takes a word when it is empty or
   // when its successor takes its current one, so a stall ripples back without loss.
   logic               valid_w [0:s2da_pkg::NUM_STAGES];
   logic               ready_w [0:s2da_pkg::NUM_STAGES];
   s2da_pkg::word_type word_w  [0:s2da_pkg::NUM_STAGES];
   logic               req_ready;

   assign req_stall = !req_ready;

   // The sign stage turns the value into sign and unsigned magnitude.
   s2da_sign u_sign (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_value  (req_value),
      .out_valid (valid_w[0]),
      .out_ready (ready_w[0]),
      .out_word  (word_w[0])
   );

   // Eight stages of eight shift-and-add-three steps each give the twenty BCD digits.
   for (genvar g = 0; g < int'(s2da_pkg::NUM_STAGES); g++) begin : g_dabble
      s2da_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[g]),
         .in_ready  (ready_w[g]),
         .in_word   (word_w[g]),
         .out_valid (valid_w[g+1]),
         .out_ready (ready_w[g+1]),
         .out_word  (word_w[g+1])
      );
   end

   // The emitter drops leading zeros and sends the sign and digits one character at a time.
   s2da_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (valid_w[s2da_pkg::NUM_STAGES]),
      .in_ready      (ready_w[s2da_pkg::NUM_STAGES]),
      .in_word       (word_w[s2da_pkg::NUM_STAGES]),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule

@@ rtl/s2da_sign.sv @@
module s2da_sign (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [s2da_pkg::VALUE_W-1:0]  in_value,
   output logic                          out_valid,
   input  logic                          out_ready,
   output s2da_pkg::word_type            out_word
);

   logic               valid_ff;
   s2da_pkg::word_type word_ff;
   s2da_pkg::word_type word_in;

   assign in_ready = !valid_ff || out_ready;

   // The magnitude is formed unsigned, so the most negative value needs no special case.
   always_comb begin
      word_in.neg = in_value[s2da_pkg::VALUE_W-1];
      word_in.bin = word_in.neg ? (~in_value + s2da_pkg::VALUE_W'(1)) : in_value;
      word_in.bcd = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

@@ rtl/s2da_dabble_stage.sv @@
module s2da_dabble_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  s2da_pkg::word_type in_word,
   output logic               out_valid,
   input  logic               out_ready,
   output s2da_pkg::word_type out_word
);

   logic               valid_ff;
   s2da_pkg::word_type word_ff;
   s2da_pkg::word_type word_in;

   assign in_ready = !valid_ff || out_ready;

   // Shift-and-add-three: each step corrects every digit of five or more, then shifts one bit in.
   always_comb begin
      word_in = in_word;
      for (int s = 0; s < int'(s2da_pkg::STEPS); s++) begin
         for (int d = 0; d < int'(s2da_pkg::NUM_DIGITS); d++) begin
            if (word_in.bcd[d*4 +: 4] >= 4'd5) begin
               word_in.bcd[d*4 +: 4] = word_in.bcd[d*4 +: 4] + 4'd3;
            end
         end
         {word_in.bcd, word_in.bin} = {word_in.bcd[s2da_pkg::BCD_W-2:0], word_in.bin, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

@@ rtl/s2da_emit.sv @@
module s2da_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  s2da_pkg::word_type in_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_char_code,
   output logic               rsp_last_char
);

   logic                          busy_ff, busy_in;
   logic                          neg_ff, neg_in;
   logic [s2da_pkg::BCD_W-1:0]    bcd_ff, bcd_in;
   logic [s2da_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                          valid_ff, valid_in;
   logic [7:0]                    char_ff, char_in;
   logic                          last_ff, last_in;
   logic [s2da_pkg::IDX_W-1:0]    top_idx;
   logic                          produce;

   assign in_ready = !busy_ff;
   assign produce  = busy_ff && (!valid_ff || !rsp_stall);

   // Index of the most significant non-zero digit; zero keeps index 0.
   always_comb begin
      top_idx = '0;
      for (int d = 0; d < int'(s2da_pkg::NUM_DIGITS); d++) begin
         if (in_word.bcd[d*4 +: 4] != 4'd0) begin
            top_idx = s2da_pkg::IDX_W'(d);
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      neg_in   = neg_ff;
      bcd_in   = bcd_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      char_in  = char_ff;
      last_in  = last_ff;
      if (produce) begin
         valid_in = 1'b1;
         if (neg_ff) begin
            char_in = s2da_pkg::CHAR_MINUS;
            last_in = 1'b0;
            neg_in  = 1'b0;
         end else begin
            char_in = s2da_pkg::CHAR_ZERO + {4'd0, bcd_ff[idx_ff*4 +: 4]};
            last_in = (idx_ff == '0);
            if (idx_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
      end else if (!busy_ff && in_valid) begin
         busy_in = 1'b1;
         neg_in  = in_word.neg;
         bcd_in  = in_word.bcd;
         idx_in  = top_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      bcd_ff  <= bcd_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;

`ifndef SYNTHESIS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff < s2da_pkg::IDX_W'(s2da_pkg::NUM_DIGITS)))
      else $error("digit index out of range");
   a_char_code: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (char_ff == s2da_pkg::CHAR_MINUS ||
                    (char_ff >= s2da_pkg::CHAR_ZERO && char_ff <= s2da_pkg::CHAR_NINE)))
      else $error("character is neither sign nor digit");
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && char_ff == s2da_pkg::CHAR_MINUS) |-> !last_ff)
      else $error("sign flagged as last character");
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      (produce && !neg_ff && idx_ff == '0) |=> !busy_ff)
      else $error("emitter still busy after last character");
`endif

endmodule

@@ sim/tb_top.sv @@
module tb_top;

   // Clock, reset and the ports of the converter.
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_char_code;
   logic        rsp_last_char;

   // One expected character of the decimal text.
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } text_char_type;

   text_char_type pending_chars[$];
   int            mismatch_count;
   int            idle_cycles;
   bit            timed_out;
   bit            quiet_phase;
   bit            send_gaps;

   signed_binary_to_decimal_ascii_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Works out the text of one word. The magnitude is taken as an unsigned
   // two's complement negation, so the most negative value needs no special
   // handling and yields its full twenty characters.
   task automatic predict_text(input logic [63:0] value);
      logic [63:0] magnitude;
      logic [3:0]  digit_list[20];
      int          count;
      begin
         magnitude = value[63] ? (~value + 64'd1) : value;
         count = 0;
         do begin
            digit_list[count] = 4'(magnitude % 64'd10);
            magnitude = magnitude / 64'd10;
            count++;
         end while (magnitude != 0 && count < s2da_pkg::NUM_DIGITS);
         if (value[63])
            pending_chars.push_back('{s2da_pkg::CHAR_MINUS, 1'b0});
         for (int i = count - 1; i >= 0; i--)
            pending_chars.push_back('{s2da_pkg::CHAR_ZERO + 8'(digit_list[i]), i == 0});
      end
   endtask

   // Sends one word, at times with a random gap in front of it when gaps are on
   // and the run is not in its quiet part; else the valid stays high into the next word.
   task automatic send_word(input logic [63:0] value);
      int gap;
      begin
         if (send_gaps && !quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_value <= value;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         predict_text(value);
      end
   endtask

   task automatic release_request;
      begin
         req_valid <= 1'b0;
      end
   endtask

   // Holds back until every character of the words sent so far has come.
   task automatic drain_text;
      begin
         release_request();
         while (pending_chars.size() != 0) @(posedge clock);
      end
   endtask

   // Extremes, zero, single digits and the powers of ten either side.
   task automatic test_directed;
      logic [63:0] corners[$];
      begin
         corners = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
                     -64'sd1, -64'sd9, -64'sd10,
                     64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                     64'h8000_0000_0000_0001, 64'd999_999_999_999_999_999,
                     64'd1_000_000_000_000_000_000, 64'hFFFF_FFFF,
                     64'h1_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
                     64'h5555_5555_5555_5555};
         send_gaps = 1'b0;
         foreach (corners[i]) send_word(corners[i]);
         // The sender waits here until all text has come out.
         drain_text();
      end
   endtask

   // Random words with a spread of lengths: about half full width, the rest
   // held to a random number of bits, some negated, so that short texts are common too.
   task automatic test_random(input int count);
      logic [63:0] value;
      int          bits;
      begin
         send_gaps = 1'b1;
         for (int n = 0; n < count; n++) begin
            value = {$urandom, $urandom};
            bits = $urandom_range(1, 64);
            if ($urandom_range(0, 1) == 0 && bits < 64) begin
               value = value & ((64'd1 << bits) - 64'd1);
               if ($urandom_range(0, 1) == 0) value = -value;
            end
            send_word(value);
         end
      end
   endtask

   // Result side: random stalls in bursts, and a check of every character.
   initial begin
      int burst;
      rsp_stall = 1'b0;
      burst = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_chars.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: char %0d last %0b",
                           rsp_char_code, rsp_last_char);
            end else begin
               text_char_type want;
               want = pending_chars.pop_front();
               if (want.char_code !== rsp_char_code ||
                   want.last_char !== rsp_last_char) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                              want.char_code, want.last_char,
                              rsp_char_code, rsp_last_char);
               end
            end
         end
         if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(0, 8);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: counts cycles in which neither side moves a request or a character.
   initial begin
      idle_cycles = 0;
      timed_out = 1'b0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= 2000 && !timed_out) begin
            timed_out = 1'b1;
            $display("FAIL signed_binary_to_decimal_ascii_unit");
            $finish;
         end
      end
   end

   initial begin
      mismatch_count = 0;
      quiet_phase = 1'b0;
      send_gaps = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(250);
      // The last part of the run goes without idling on either side.
      quiet_phase = 1'b1;
      test_random(60);
      drain_text();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && pending_chars.size() == 0) begin
         $display("PASS signed_binary_to_decimal_ascii_unit");
      end else begin
         $display("FAIL signed_binary_to_decimal_ascii_unit");
      end
      $finish;
   end

endmodule
